// ===== rtl/core/mst_pkg.sv =====
package mst_pkg;
  localparam int DEF_MAX_ELEMENTS = 1024;
  localparam int DEF_VALUE_BITS   = 16;
endpackage

// ===== rtl/core/max_subarray_segment_tree.sv =====
// Maximum-subarray segment tree.
// Keeps best run sum, total, best prefix and best suffix for every node of a
// segment tree over element_count signed values.
// Command channel: a beat is taken when start is high and busy is low.
// mode 0 writes new_value at position and refreshes the path to the root.
// A position at or past the element count is dropped. It gives no result.
// mode 1 queries [range_first, range_last]. One result beat follows, with
// done high for one cycle. status is 1 for an empty range or one that runs
// past the count, and the four sums are then zero.
// The receiver cannot stall: done marks each result for exactly one cycle.
// A write descends the tree to the leaf and writes it, then for each level
// reads the sibling and writes the merged parent. A query walks a node stack at
// one node a cycle, except that it stops in a merge state for each node it merges.
// All nodes live in one memory with a registered read port; every merge
// waits on that read port.
// Reset clears all 4*MAX_ELEMENTS node words in a sweep, with
// busy high throughout; element_count may be written during the sweep.
// element_count is written at any edge with element_count_we high; keeping that to idle is up to the user.
module max_subarray_segment_tree #(
  parameter int MAX_ELEMENTS = mst_pkg::DEF_MAX_ELEMENTS,
  parameter int VALUE_BITS   = mst_pkg::DEF_VALUE_BITS,
  localparam int PW = $clog2(MAX_ELEMENTS),
  localparam int CW = PW + 1,
  localparam int SW = VALUE_BITS + PW
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         element_count_we,
  input  logic [CW-1:0]                element_count,
  input  logic                         start,
  output logic                         busy,
  input  logic                         mode,
  input  logic [PW-1:0]                position,
  input  logic signed [VALUE_BITS-1:0] new_value,
  input  logic [PW-1:0]                range_first,
  input  logic [PW-1:0]                range_last,
  output logic                         done,
  output logic signed [SW-1:0]         best_sum,
  output logic signed [SW-1:0]         range_total,
  output logic signed [SW-1:0]         best_prefix,
  output logic signed [SW-1:0]         best_suffix,
  output logic                         status
);
  localparam int DEPTH = 4 * MAX_ELEMENTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int LV    = PW + 1;
  localparam int SD    = 2 * LV;
  localparam int SIW   = $clog2(SD);

  typedef struct packed {
    logic signed [SW-1:0] best;
    logic signed [SW-1:0] total;
    logic signed [SW-1:0] prefix;
    logic signed [SW-1:0] suffix;
  } node_t;

  typedef struct packed {
    logic [PW-1:0] s;
    logic [PW-1:0] e;
    logic [AW-1:0] k;
  } ent_t;

  typedef enum logic [2:0] {
    CLEAR, IDLE, WDESC, WUP, WUPD, QPOP, QACC
  } state_t;

  function automatic logic signed [SW-1:0] max2(logic signed [SW-1:0] a,
                                                logic signed [SW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic node_t comb(node_t l, node_t r);
    node_t c;
    c.best   = max2(max2(l.best, r.best), l.suffix + r.prefix);
    c.total  = l.total + r.total;
    c.prefix = max2(l.prefix, l.total + r.prefix);
    c.suffix = max2(r.suffix, l.suffix + r.total);
    return c;
  endfunction

  state_t        state;
  logic [CW-1:0] cnt;
  logic [AW-1:0] clr_addr;
  logic [PW-1:0] ws, we_, wpos;
  logic [AW-1:0] wk;
  node_t         cur;
  node_t         acc;
  logic          acc_v;
  logic [PW-1:0] qlo, qhi;
  ent_t          stk [SD];
  logic [SIW:0]  sp;

  node_t         mem [DEPTH];
  node_t         rd;
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  node_t         mem_wd;

  // Clamp the element count to 1..MAX_ELEMENTS
  logic [CW-1:0] n;
  logic [PW-1:0] root_e;
  always_comb begin
    if (cnt == '0) n = CW'(1);
    else if (cnt > CW'(MAX_ELEMENTS)) n = CW'(MAX_ELEMENTS);
    else n = cnt;
  end
  assign root_e = PW'(n - CW'(1));

  // Write descent split
  logic [PW-1:0] wmid;
  assign wmid = PW'(({1'b0, ws} + {1'b0, we_}) >> 1);

  // Query stack top and its split
  logic [SIW-1:0] ti, ni;
  ent_t           top;
  logic [PW-1:0]  tmid;
  logic           t_out, t_in;
  assign ti    = SIW'(sp - (SIW+1)'(1));
  assign ni    = SIW'(sp);
  assign top   = stk[ti];
  assign tmid  = PW'(({1'b0, top.s} + {1'b0, top.e}) >> 1);
  assign t_out = (top.s > qhi) || (top.e < qlo);
  assign t_in  = (top.s >= qlo) && (top.e <= qhi);

  // Leaf and parent values
  logic signed [VALUE_BITS-1:0] new_value_r;
  node_t leaf, up_node;
  logic signed [SW-1:0] vext;
  assign vext = {{(SW-VALUE_BITS){new_value_r[VALUE_BITS-1]}}, new_value_r};
  assign leaf = '{best: vext, total: vext, prefix: vext, suffix: vext};
  assign up_node = wk[0] ? comb(rd, cur) : comb(cur, rd);

  // Memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = wk;
    mem_wd = leaf;
    mem_ra = wk ^ AW'(1);
    case (state)
      CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr;
        mem_wd = '0;
      end
      WDESC: begin
        mem_we = (ws == we_);
      end
      WUPD: begin
        mem_we = 1'b1;
        mem_wa = {1'b0, wk[AW-1:1]};
        mem_wd = up_node;
      end
      QPOP: begin
        mem_ra = top.k;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Node memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd <= mem[mem_ra];
  end

  assign busy = (state != IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= CLEAR;
      cnt      <= CW'(MAX_ELEMENTS);
      clr_addr <= '0;
      done     <= 1'b0;
      sp       <= '0;
      acc_v    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (element_count_we) cnt <= element_count;
      case (state)
        CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) state <= IDLE;
        end
        IDLE: begin
          if (start) begin
            if (!mode) begin
              // take a write beat
              if ({1'b0, position} < n) begin
                ws          <= '0;
                we_         <= root_e;
                wk          <= AW'(1);
                wpos        <= position;
                new_value_r <= new_value;
                state       <= WDESC;
              end
            end else if (range_first > range_last || {1'b0, range_last} >= n) begin
              // flag a bad range at once
              done        <= 1'b1;
              status      <= 1'b1;
              best_sum    <= '0;
              range_total <= '0;
              best_prefix <= '0;
              best_suffix <= '0;
            end else begin
              qlo     <= range_first;
              qhi     <= range_last;
              stk[0]  <= '{s: '0, e: root_e, k: AW'(1)};
              sp      <= (SIW+1)'(1);
              acc_v   <= 1'b0;
              state   <= QPOP;
            end
          end
        end
        WDESC: begin
          // descend toward the leaf
          if (ws == we_) begin
            cur <= leaf;
            state <= (wk == AW'(1)) ? IDLE : WUP;
          end else if (wpos > wmid) begin
            ws <= wmid + PW'(1);
            wk <= {wk[AW-2:0], 1'b1};
          end else begin
            we_ <= wmid;
            wk  <= {wk[AW-2:0], 1'b0};
          end
        end
        WUP: begin
          state <= WUPD;
        end
        WUPD: begin
          // merge with sibling, advance to parent
          cur <= up_node;
          wk  <= {1'b0, wk[AW-1:1]};
          state <= (wk[AW-1:1] == (AW-1)'(1)) ? IDLE : WUP;
        end
        QPOP: begin
          if (sp == '0) begin
            done        <= 1'b1;
            status      <= 1'b0;
            best_sum    <= acc.best;
            range_total <= acc.total;
            best_prefix <= acc.prefix;
            best_suffix <= acc.suffix;
            state       <= IDLE;
          end else if (t_out) begin
            sp <= sp - (SIW+1)'(1);
          end else if (t_in) begin
            sp <= sp - (SIW+1)'(1);
            state <= QACC;
          end else begin
            // replace top with right half, push left half
            stk[ti] <= '{s: tmid + PW'(1), e: top.e, k: {top.k[AW-2:0], 1'b1}};
            stk[ni] <= '{s: top.s, e: tmid, k: {top.k[AW-2:0], 1'b0}};
            sp <= sp + (SIW+1)'(1);
          end
        end
        QACC: begin
          acc   <= acc_v ? comb(acc, rd) : rd;
          acc_v <= 1'b1;
          state <= QPOP;
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule
